[design/mlp_two_two_two_sigmoid_infer_macros.svh]
// ----------------------------------------------------------------------------
// MLP 2-2-2 assertion macros
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef MLP_TWO_TWO_TWO_SIGMOID_INFER_MACROS_SVH
`define MLP_TWO_TWO_TWO_SIGMOID_INFER_MACROS_SVH

// same-cycle implication, disabled during reset
`define MLP222_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define MLP222_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/mlp222_pkg.sv]
// ----------------------------------------------------------------------------
// MLP 2-2-2 package
// Widths, register indexes and the elaboration-time sigmoid table generator.
// ----------------------------------------------------------------------------
package mlp222_pkg;

	localparam int SIGMOID_ENTRIES = 256;

	localparam int DATA_W    = 16;
	localparam int WGT_W     = 16;
	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_A = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_B = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_A = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_B = 8'd3;

	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
	localparam logic [63:0] ONE_Q15 = 64'd32768;

	// restoring long division, elaboration use only
	function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// e^-a, Q.30 in and out: series of e^-(a/16), then four squarings
	function automatic logic [63:0] exp_neg_q30(input logic [63:0] a);
		logic [63:0]        t;
		logic [63:0]        term;
		logic [63:0]        v;
		logic signed [63:0] acc;
		t    = a >> 4;
		term = ONE_Q30;
		acc  = $signed(ONE_Q30);
		for (int k = 1; k <= 16; k++) begin
			term = udiv((term * t) >> 30, 64'(k));
			if ((k & 1) != 0)
				acc = acc - $signed(term);
			else
				acc = acc + $signed(term);
		end
		v = $unsigned(acc);
		for (int sq = 0; sq < 4; sq++)
			v = (v * v + (ONE_Q30 >> 1)) >> 30;
		return v;
	endfunction

	// table entry i of n bins over [-8,8), Q1.15
	function automatic logic [15:0] sigmoid_entry(input int i, input int n);
		logic signed [63:0] twice;
		logic [63:0]        mag;
		logic [63:0]        ax;
		logic [63:0]        den;
		logic [63:0]        pos;
		twice = 64'(2 * i + 1 - n);
		mag   = (twice < 0) ? $unsigned(-twice) : $unsigned(twice);
		ax    = udiv(mag << 33, 64'(n));
		den   = ONE_Q30 + exp_neg_q30(ax);
		pos   = udiv((ONE_Q15 << 30) + (den >> 1), den);
		if (twice < 0)
			return 16'(ONE_Q15 - pos);
		return 16'(pos);
	endfunction

endpackage

[design/mlp222_ifs.sv]
// ----------------------------------------------------------------------------
// MLP 2-2-2 channel interfaces
// Feature request, prediction result and weight write channels.
// ----------------------------------------------------------------------------
interface mlp222_feat_if;
	logic                          valid;
	logic                          ready;
	logic [mlp222_pkg::DATA_W-1:0] feature_one;
	logic [mlp222_pkg::DATA_W-1:0] feature_two;

	modport source(output valid, feature_one, feature_two, input ready);
	modport sink(input valid, feature_one, feature_two, output ready);
endinterface

interface mlp222_pred_if;
	logic                          valid;
	logic                          ready;
	logic [mlp222_pkg::DATA_W-1:0] prediction_one;
	logic [mlp222_pkg::DATA_W-1:0] prediction_two;

	modport source(output valid, prediction_one, prediction_two, input ready);
	modport sink(input valid, prediction_one, prediction_two, output ready);
endinterface

interface mlp222_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [mlp222_pkg::CFG_IDX_W-1:0] index;
	logic [mlp222_pkg::CFG_W-1:0]     data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[design/mlp222_layer.sv]
// ----------------------------------------------------------------------------
// MLP 2-2-2 layer
// Two sigmoid neurons over bias and two Q1.15 inputs, four pipeline stages:
// products, sum and clamp, bin index, table read.
// ----------------------------------------------------------------------------
module mlp222_layer #(
	parameter int SIGMOID_ENTRIES = mlp222_pkg::SIGMOID_ENTRIES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mlp222_pkg::DATA_W-1:0]       in_a,
	input  logic [mlp222_pkg::DATA_W-1:0]       in_b,
	input  logic [1:0][mlp222_pkg::CFG_W-1:0]   wgt,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mlp222_pkg::DATA_W-1:0]       out_a,
	output logic [mlp222_pkg::DATA_W-1:0]       out_b
);

	localparam int IDX_W = $clog2(SIGMOID_ENTRIES);
	localparam int NW    = $clog2(SIGMOID_ENTRIES + 1);
	localparam int PW    = 31 + NW;
	localparam logic [NW-1:0]    ENTRIES_V = NW'(SIGMOID_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SIGMOID_ENTRIES - 1);
	localparam logic signed [34:0] SAT_LIM = 35'sd1073741824;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic [15:0] rom [SIGMOID_ENTRIES];

	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	for (genvar g = 0; g < SIGMOID_ENTRIES; g++) begin : g_rom
		localparam logic [15:0] ENTRY = mlp222_pkg::sigmoid_entry(g, SIGMOID_ENTRIES);
		assign rom[g] = ENTRY;
	end

	for (genvar n = 0; n < 2; n++) begin : g_neu
		logic signed [15:0] w0, w1, w2;
		logic signed [34:0] sum;
		logic [PW-1:0]      prod;
		logic signed [30:0] bias_s1;
		logic signed [32:0] p1_s1;
		logic signed [32:0] p2_s1;
		logic               lo_s2;
		logic               hi_s2;
		logic [30:0]        off_s2;
		logic [IDX_W-1:0]   idx_s3;
		logic [15:0]        act_s4;

		assign w0 = wgt[n][15:0];
		assign w1 = wgt[n][31:16];
		assign w2 = wgt[n][47:32];

		assign sum  = 35'(bias_s1) + 35'(p1_s1) + 35'(p2_s1);
		assign prod = PW'(off_s2) * PW'(ENTRIES_V);

		always_ff @(posedge clk) begin
			if (en1) begin
				bias_s1 <= {w0, 15'b0};
				p1_s1   <= w1 * $signed({1'b0, in_a});
				p2_s1   <= w2 * $signed({1'b0, in_b});
			end
			if (en2) begin
				lo_s2  <= sum < -SAT_LIM;
				hi_s2  <= sum >= SAT_LIM;
				off_s2 <= 31'(sum + SAT_LIM);
			end
			if (en3) begin
				if (lo_s2)
					idx_s3 <= '0;
				else if (hi_s2)
					idx_s3 <= LAST_IDX;
				else
					idx_s3 <= prod[31 +: IDX_W];
			end
			if (en4)
				act_s4 <= rom[idx_s3];
		end
	end

	assign out_valid = v_s4;
	assign out_a     = g_neu[0].act_s4;
	assign out_b     = g_neu[1].act_s4;

endmodule

[design/mlp_two_two_two_sigmoid_infer.sv]
// ----------------------------------------------------------------------------
// MLP 2-2-2 sigmoid inference
// Pipeline: two 4-stage layers between request accept and result valid.
// Throughput: one request per cycle while pred.ready holds; each stage holds only while the stage
// after it is full and stalled, so bubbles close up under backpressure.
// Reset: pipeline valids and all weight registers clear to zero.
// ----------------------------------------------------------------------------
module mlp_two_two_two_sigmoid_infer #(
	parameter int SIGMOID_ENTRIES = mlp222_pkg::SIGMOID_ENTRIES
) (
	input  logic          clk,
	input  logic          arst_n,
	mlp222_feat_if.sink   feat,
	mlp222_pred_if.source pred,
	mlp222_cfg_if.sink    cfg
);

	logic [mlp222_pkg::CFG_W-1:0] hid_a_q, hid_b_q, out_a_q, out_b_q;

	logic                          hid_valid;
	logic                          hid_ready;
	logic [mlp222_pkg::DATA_W-1:0] hid_a;
	logic [mlp222_pkg::DATA_W-1:0] hid_b;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hid_a_q <= '0;
			hid_b_q <= '0;
			out_a_q <= '0;
			out_b_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				mlp222_pkg::REG_HIDDEN_A: hid_a_q <= cfg.data;
				mlp222_pkg::REG_HIDDEN_B: hid_b_q <= cfg.data;
				mlp222_pkg::REG_OUTPUT_A: out_a_q <= cfg.data;
				mlp222_pkg::REG_OUTPUT_B: out_b_q <= cfg.data;
				default: ;
			endcase
		end
	end

	mlp222_layer #(
		.SIGMOID_ENTRIES(SIGMOID_ENTRIES)
	) u_hidden (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (feat.valid),
		.in_ready (feat.ready),
		.in_a     (feat.feature_one),
		.in_b     (feat.feature_two),
		.wgt      ({hid_b_q, hid_a_q}),
		.out_valid(hid_valid),
		.out_ready(hid_ready),
		.out_a    (hid_a),
		.out_b    (hid_b)
	);

	mlp222_layer #(
		.SIGMOID_ENTRIES(SIGMOID_ENTRIES)
	) u_output (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (hid_valid),
		.in_ready (hid_ready),
		.in_a     (hid_a),
		.in_b     (hid_b),
		.wgt      ({out_b_q, out_a_q}),
		.out_valid(pred.valid),
		.out_ready(pred.ready),
		.out_a    (pred.prediction_one),
		.out_b    (pred.prediction_two)
	);

endmodule

[design/mlp222_chk.sv]
// ----------------------------------------------------------------------------
// MLP 2-2-2 port checker
// Watches the top-level ports for stall, reset and range behavior.
// ----------------------------------------------------------------------------
`include "mlp_two_two_two_sigmoid_infer_macros.svh"

module mlp222_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        feat_ready,
	input logic        pred_valid,
	input logic        pred_ready,
	input logic [15:0] pred_one,
	input logic [15:0] pred_two
);

	`MLP222_ASSERT_NEXT(a_pred_hold, clk, arst_n, pred_valid && !pred_ready, pred_valid && $stable(pred_one) && $stable(pred_two), "stalled result changed")
	`MLP222_ASSERT_NOW(a_reset_empty, clk, arst_n, $rose(arst_n), !pred_valid, "result valid out of reset")
	`MLP222_ASSERT_NOW(a_pred_range, clk, arst_n, pred_valid, pred_one <= 16'd32768 && pred_two <= 16'd32768, "activation above 1.0")
	`MLP222_ASSERT_NOW(a_ready_idle, clk, arst_n, !pred_valid, feat_ready, "request blocked with empty output")

endmodule

bind mlp_two_two_two_sigmoid_infer mlp222_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.feat_ready(feat.ready),
	.pred_valid(pred.valid),
	.pred_ready(pred.ready),
	.pred_one  (pred.prediction_one),
	.pred_two  (pred.prediction_two)
);

[dv/mlp_two_two_two_sigmoid_infer_tb.sv]
// ----------------------------------------------------------------------------
// MLP 2-2-2 sigmoid inference testbench
// Streams feature requests through the block and checks each prediction
// against an in-bench fixed-point model of the forward pass. The model has
// its own weights and sigmoid table. The run steps through several weight
// settings, including the extremes. Both channels idle at random, and the
// result side is held off once for a long stretch so the pipeline fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mlp_two_two_two_sigmoid_infer_tb;

	localparam int          BINS      = mlp222_pkg::SIGMOID_ENTRIES;
	localparam int          BIN_W     = $clog2(BINS);
	localparam logic [63:0] BINS_U    = 64'(BINS);
	localparam logic signed [63:0] SUM_EIGHT = 64'sd1073741824;
	localparam int          DRAIN_CYC = 12;
	localparam int          HOLD_CYC  = 200;

	typedef struct packed {
		logic [mlp222_pkg::DATA_W-1:0] f1;
		logic [mlp222_pkg::DATA_W-1:0] f2;
	} feature_req_t;

	typedef struct packed {
		logic [mlp222_pkg::DATA_W-1:0] p1;
		logic [mlp222_pkg::DATA_W-1:0] p2;
	} prediction_t;

	logic clk;
	logic arst_n;

	mlp222_feat_if feat_ch();
	mlp222_pred_if pred_ch();
	mlp222_cfg_if  cfg_ch();

	mlp_two_two_two_sigmoid_infer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.feat   (feat_ch),
		.pred   (pred_ch),
		.cfg    (cfg_ch)
	);

	// model state
	logic [mlp222_pkg::CFG_W-1:0]  hid_a_w = '0;
	logic [mlp222_pkg::CFG_W-1:0]  hid_b_w = '0;
	logic [mlp222_pkg::CFG_W-1:0]  out_a_w = '0;
	logic [mlp222_pkg::CFG_W-1:0]  out_b_w = '0;
	logic [mlp222_pkg::DATA_W-1:0] sig_rom [BINS];

	feature_req_t feature_requests[$];
	prediction_t  predicted_outputs[$];
	feature_req_t next_req;
	prediction_t  want_pred;

	int   mismatches     = 0;
	int   accepted_total = 0;
	int   src_gap        = 0;
	int   snk_gap        = 0;
	logic quiet_tail     = 1'b0;
	logic sink_hold      = 1'b0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// e^-arg, Q.30: series of e^-(arg/16), then four squarings
	function automatic logic [63:0] decay_q30(input logic [63:0] arg);
		logic [63:0]        step_v;
		logic [63:0]        term;
		logic [63:0]        v;
		logic signed [63:0] acc;
		step_v = arg >> 4;
		term   = 64'd1 << 30;
		acc    = 64'sd1 <<< 30;
		for (int k = 1; k <= 16; k++) begin
			term = ((term * step_v) >> 30) / 64'(unsigned'(k));
			if (k % 2 == 1)
				acc = acc - $signed(term);
			else
				acc = acc + $signed(term);
		end
		v = $unsigned(acc);
		repeat (4)
			v = (v * v + (64'd1 << 29)) >> 30;
		return v;
	endfunction

	function automatic logic [mlp222_pkg::DATA_W-1:0] rom_entry(input int i);
		logic signed [63:0] twice;
		logic [63:0]        mag;
		logic [63:0]        ax;
		logic [63:0]        den;
		logic [63:0]        pos;
		twice = 64'(2 * i + 1 - BINS);
		mag   = (twice < 0) ? $unsigned(-twice) : $unsigned(twice);
		ax    = (mag << 33) / BINS_U;
		den   = (64'd1 << 30) + decay_q30(ax);
		pos   = ((64'd32768 << 30) + (den >> 1)) / den;
		if (twice < 0)
			return 16'(64'd32768 - pos);
		return 16'(pos);
	endfunction

	// sum in Q.27, saturating outside [-8,8)
	function automatic logic [mlp222_pkg::DATA_W-1:0] squash(input logic signed [63:0] acc_sum);
		logic [63:0] bin;
		if (acc_sum < -SUM_EIGHT)
			bin = 64'd0;
		else if (acc_sum >= SUM_EIGHT)
			bin = BINS_U - 64'd1;
		else
			bin = ($unsigned(acc_sum + SUM_EIGHT) * BINS_U) >> 31;
		return sig_rom[bin[BIN_W-1:0]];
	endfunction

	function automatic logic [mlp222_pkg::DATA_W-1:0] neuron_out(
			input logic [mlp222_pkg::CFG_W-1:0] w,
			input logic [mlp222_pkg::DATA_W-1:0] x1, input logic [mlp222_pkg::DATA_W-1:0] x2);
		logic signed [63:0] wb;
		logic signed [63:0] w1;
		logic signed [63:0] w2;
		logic signed [63:0] i1;
		logic signed [63:0] i2;
		wb = $signed(w[15:0]);
		w1 = $signed(w[31:16]);
		w2 = $signed(w[47:32]);
		i1 = {48'd0, x1};
		i2 = {48'd0, x2};
		return squash(wb * 64'sd32768 + w1 * i1 + w2 * i2);
	endfunction

	function automatic prediction_t predict_outputs(input logic [mlp222_pkg::DATA_W-1:0] x1,
			input logic [mlp222_pkg::DATA_W-1:0] x2);
		logic [mlp222_pkg::DATA_W-1:0] ha;
		logic [mlp222_pkg::DATA_W-1:0] hb;
		prediction_t                   res;
		ha     = neuron_out(hid_a_w, x1, x2);
		hb     = neuron_out(hid_b_w, x1, x2);
		res.p1 = neuron_out(out_a_w, ha, hb);
		res.p2 = neuron_out(out_b_w, ha, hb);
		return res;
	endfunction

	function automatic logic [mlp222_pkg::WGT_W-1:0] rand_weight();
		case ($urandom_range(0, 3))
			0: return mlp222_pkg::WGT_W'($urandom);
			1, 2: return mlp222_pkg::WGT_W'($urandom_range(0, 16383) - 8192);
			default: return mlp222_pkg::WGT_W'($urandom_range(0, 2047) - 1024);
		endcase
	endfunction

	function automatic logic [mlp222_pkg::DATA_W-1:0] rand_feature();
		if ($urandom_range(0, 9) < 8)
			return mlp222_pkg::DATA_W'($urandom_range(0, 32768));
		return mlp222_pkg::DATA_W'($urandom);
	endfunction

	task automatic flag_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic queue_item(input logic [mlp222_pkg::DATA_W-1:0] x1,
			input logic [mlp222_pkg::DATA_W-1:0] x2);
		feature_req_t req;
		req.f1 = x1;
		req.f2 = x2;
		feature_requests.insert(feature_requests.size(), req);
	endtask

	// entered just after a rising edge, returns just after one
	task automatic write_weights(input logic [mlp222_pkg::CFG_IDX_W-1:0] idx,
			input logic [mlp222_pkg::CFG_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			mlp222_pkg::REG_HIDDEN_A: hid_a_w = value;
			mlp222_pkg::REG_HIDDEN_B: hid_b_w = value;
			mlp222_pkg::REG_OUTPUT_A: out_a_w = value;
			mlp222_pkg::REG_OUTPUT_B: out_b_w = value;
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(input logic [mlp222_pkg::CFG_W-1:0] ha,
			input logic [mlp222_pkg::CFG_W-1:0] hb,
			input logic [mlp222_pkg::CFG_W-1:0] oa, input logic [mlp222_pkg::CFG_W-1:0] ob);
		write_weights(mlp222_pkg::REG_HIDDEN_A, ha);
		write_weights(mlp222_pkg::REG_HIDDEN_B, hb);
		write_weights(mlp222_pkg::REG_OUTPUT_A, oa);
		write_weights(mlp222_pkg::REG_OUTPUT_B, ob);
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (feature_requests.size() != 0 || feat_ch.valid || predicted_outputs.size() != 0);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feat_ch.valid       <= 1'b0;
			feat_ch.feature_one <= '0;
			feat_ch.feature_two <= '0;
			src_gap = 0;
		end else begin
			if (feat_ch.valid && feat_ch.ready) begin
				predicted_outputs.insert(predicted_outputs.size(),
					predict_outputs(feat_ch.feature_one, feat_ch.feature_two));
				accepted_total <= accepted_total + 1;
			end
			if (!feat_ch.valid || feat_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					feat_ch.valid <= 1'b0;
				end else if (feature_requests.size() > 0) begin
					next_req = feature_requests.pop_front();
					feat_ch.feature_one <= next_req.f1;
					feat_ch.feature_two <= next_req.f2;
					feat_ch.valid       <= 1'b1;
					if (!quiet_tail && $urandom_range(0, 15) == 0)
						src_gap = $urandom_range(1, 19);
				end else begin
					feat_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_ch.ready <= 1'b0;
			snk_gap = 0;
		end else begin
			if (pred_ch.valid && pred_ch.ready) begin
				if (predicted_outputs.size() == 0) begin
					flag_mismatch($sformatf("unexpected prediction %h/%h",
						pred_ch.prediction_one, pred_ch.prediction_two));
				end else begin
					want_pred = predicted_outputs.pop_front();
					if (pred_ch.prediction_one !== want_pred.p1 ||
							pred_ch.prediction_two !== want_pred.p2)
						flag_mismatch($sformatf("prediction got %h/%h want %h/%h",
							pred_ch.prediction_one, pred_ch.prediction_two,
							want_pred.p1, want_pred.p2));
				end
			end
			if (sink_hold) begin
				pred_ch.ready <= 1'b0;
			end else if (snk_gap > 0) begin
				snk_gap--;
				pred_ch.ready <= 1'b0;
			end else begin
				pred_ch.ready <= 1'b1;
				if (!quiet_tail && $urandom_range(0, 15) == 0)
					snk_gap = $urandom_range(1, 19);
			end
		end
	end

	// long result hold-off while requests keep coming
	initial begin
		wait (accepted_total >= 400);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (HOLD_CYC) @(posedge clk);
		sink_hold <= 1'b0;
	end

	initial begin
		#5000000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data  = '0;
		for (int i = 0; i < BINS; i++)
			sig_rom[i] = rom_entry(i);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// weights at reset value
		queue_item(16'd0, 16'd0);
		queue_item(16'd32768, 16'd32768);
		queue_item(16'hFFFF, 16'd0);
		settle();

		// sum exactly +8 and just below, sum below -8, sum exactly -8,
		// out-of-range register indexes ignored
		write_all({16'h0000, 16'h0001, 16'h7FFF}, 48'h8000_8000_8000,
			48'h7FFF_7FFF_7FFF, {16'h0000, 16'h0000, 16'h8000});
		write_weights(8'd4, mlp222_pkg::CFG_W'({$urandom, $urandom}));
		write_weights(8'hFF, mlp222_pkg::CFG_W'({$urandom, $urandom}));
		queue_item(16'd32768, 16'd0);
		queue_item(16'd32767, 16'd0);
		queue_item(16'd0, 16'd0);
		queue_item(16'hFFFF, 16'hFFFF);
		queue_item(16'd1, 16'd1);
		queue_item(16'h5555, 16'hAAAA);
		queue_item(16'hAAAA, 16'h5555);
		queue_item(16'd32768, 16'd32768);
		settle();

		write_all(48'hFFFF_FFFF_FFFF, {16'h0000, 16'h0000, 16'h8000},
			48'hFFFF_FFFF_FFFF, {16'h7FFF, 16'h8000, 16'h0800});
		queue_item(16'd0, 16'hFFFF);
		queue_item(16'hFFFF, 16'd0);
		queue_item(16'd0, 16'd32768);
		queue_item(16'd12345, 16'd23456);
		queue_item(16'd32768, 16'd1);
		queue_item(16'hFFFF, 16'hFFFF);
		settle();

		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 4)
				quiet_tail <= 1'b1;
			write_all({rand_weight(), rand_weight(), rand_weight()},
				{rand_weight(), rand_weight(), rand_weight()},
				{rand_weight(), rand_weight(), rand_weight()},
				{rand_weight(), rand_weight(), rand_weight()});
			for (int n = 0; n < 320; n++)
				queue_item(rand_feature(), rand_feature());
			settle();
		end

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
